// ===== rtl/keypad_code_lock_controller_assert.svh =====
// ----------------------------------------------------------------------------
// keypad code lock assertion macros
// shared concurrent assertion forms, clocked on clk_i and off during reset
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_ASSERT_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_ASSERT_SVH

// property holds at every edge
`define KCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent follows the antecedent through a non-overlapping implication
`define KCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kcl_pkg.sv =====
// ----------------------------------------------------------------------------
// kcl_pkg
// types and constants shared by the keypad code lock controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kcl_pkg;

  // screens
  localparam logic [3:0] SCR_ENTER    = 4'd0;
  localparam logic [3:0] SCR_OLD      = 4'd1;
  localparam logic [3:0] SCR_CONFIRM  = 4'd2;
  localparam logic [3:0] SCR_NEW      = 4'd3;
  localparam logic [3:0] SCR_CHANGED  = 4'd4;
  localparam logic [3:0] SCR_MISMATCH = 4'd5;
  localparam logic [3:0] SCR_WRONG    = 4'd6;
  localparam logic [3:0] SCR_GRANTED  = 4'd7;
  localparam logic [3:0] SCR_CLOCK    = 4'd8;

  // change mode stages
  localparam logic [1:0] STG_OLD     = 2'd0;
  localparam logic [1:0] STG_NEW     = 2'd1;
  localparam logic [1:0] STG_CONFIRM = 2'd2;

  // register indexes
  localparam logic [2:0] REG_CONFIRM_KEY   = 3'd0;
  localparam logic [2:0] REG_CLEAR_KEY     = 3'd1;
  localparam logic [2:0] REG_CHANGE_KEY    = 3'd2;
  localparam logic [2:0] REG_BACKLIGHT_KEY = 3'd3;
  localparam logic [2:0] REG_REBOOT_KEY    = 3'd4;
  localparam logic [2:0] REG_IDLE_LIMIT    = 3'd5;
  localparam logic [2:0] REG_MESSAGE_LIMIT = 3'd6;
  localparam logic [2:0] REG_INITIAL_CODE  = 3'd7;

  // register reset values
  localparam logic [7:0]  RST_CONFIRM_KEY   = 8'd35;
  localparam logic [7:0]  RST_CLEAR_KEY     = 8'd42;
  localparam logic [7:0]  RST_CHANGE_KEY    = 8'd65;
  localparam logic [7:0]  RST_BACKLIGHT_KEY = 8'd66;
  localparam logic [7:0]  RST_REBOOT_KEY    = 8'd68;
  localparam logic [15:0] RST_IDLE_LIMIT    = 16'd5000;
  localparam logic [15:0] RST_MESSAGE_LIMIT = 16'd2000;
  localparam logic [63:0] RST_INITIAL_CODE  = 64'd0;

  // literal 'C' also counts as a clear key
  localparam logic [7:0] CLEAR_ALT_KEY = 8'd67;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // request queue
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  // classified request
  typedef struct packed {
    logic       is_tick;
    logic       is_reboot;
    logic       is_backlight;
    logic       is_change;
    logic       is_confirm;
    logic       is_clear;
    logic [7:0] key;
  } req_t;

  // limits seen by the back end
  typedef struct packed {
    logic [15:0] idle_limit;
    logic [15:0] message_limit;
  } limits_t;

  // stored code load from the register port
  typedef struct packed {
    logic        load;
    logic [63:0] value;
  } code_load_t;

  // result, first field in the highest bits
  typedef struct packed {
    logic [63:0] new_code;
    logic        save_code;
    logic        reboot_request;
    logic        backlight_on;
    logic        bad_tone;
    logic        good_tone;
    logic        unlock_pulse;
    logic [3:0]  digits_entered;
    logic [3:0]  screen;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned OUT_W    = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== rtl/keypad_code_lock_controller.sv =====
// ----------------------------------------------------------------------------
// keypad_code_lock_controller
// keypad code lock: key presses and ticks in, one status result per request.
// a request is queued, then executed into the registered result.
// throughput: one request per cycle unless the result output is stalled.
// a two-entry request queue and the result register decouple both sides.
// reset: asynchronous active low, key registers and limits to defaults,
// stored code zero, backlight on, screen 0; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_code_lock_controller import kcl_pkg::*; #(
  parameter int unsigned CODE_DIGITS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [7:0]       s_axis_tdata_i,   // key_code
  input  logic             s_axis_tuser_i,   // req_type
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // screen, digits_entered, unlock_pulse, good_tone, bad_tone, backlight_on,
  // reboot_request, save_code, new_code, zero fill
  output logic [OUT_W-1:0] m_axis_tdata_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [63:0]      cfg_data_i
);

  req_t       push_req;
  req_t       pop_req;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  limits_t    limits;
  code_load_t code_load;
  result_t    result;

  kcl_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .req_o           (push_req),
    .limits_o        (limits),
    .code_load_o     (code_load)
  );

  kcl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_req),
    .pop_i   (pop),
    .rdata_o (pop_req),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  kcl_back #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .req_i       (pop_req),
    .pop_o       (pop),
    .limits_i    (limits),
    .code_load_i (code_load),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (result)
  );

  assign m_axis_tdata_o = {{(OUT_W - RESULT_W){1'b0}}, result};

endmodule

// ===== rtl/kcl_front.sv =====
// ----------------------------------------------------------------------------
// kcl_front
// register port and request intake; classifies each key against the key
// registers and pushes the request into the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kcl_front import kcl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        q_full_i,
  output logic        push_o,
  output req_t        req_o,
  output limits_t     limits_o,
  output code_load_t  code_load_o
);

  logic [7:0]  confirm_key_q, confirm_key_d;
  logic [7:0]  clear_key_q, clear_key_d;
  logic [7:0]  change_key_q, change_key_d;
  logic [7:0]  backlight_key_q, backlight_key_d;
  logic [7:0]  reboot_key_q, reboot_key_d;
  logic [15:0] idle_limit_q, idle_limit_d;
  logic [15:0] message_limit_q, message_limit_d;
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    confirm_key_d   = confirm_key_q;
    clear_key_d     = clear_key_q;
    change_key_d    = change_key_q;
    backlight_key_d = backlight_key_q;
    reboot_key_d    = reboot_key_q;
    idle_limit_d    = idle_limit_q;
    message_limit_d = message_limit_q;
    if (cfg_we) begin
      case (cfg_index_i)
        REG_CONFIRM_KEY:   confirm_key_d   = cfg_data_i[7:0];
        REG_CLEAR_KEY:     clear_key_d     = cfg_data_i[7:0];
        REG_CHANGE_KEY:    change_key_d    = cfg_data_i[7:0];
        REG_BACKLIGHT_KEY: backlight_key_d = cfg_data_i[7:0];
        REG_REBOOT_KEY:    reboot_key_d    = cfg_data_i[7:0];
        REG_IDLE_LIMIT:    idle_limit_d    = cfg_data_i[15:0];
        REG_MESSAGE_LIMIT: message_limit_d = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      confirm_key_q   <= RST_CONFIRM_KEY;
      clear_key_q     <= RST_CLEAR_KEY;
      change_key_q    <= RST_CHANGE_KEY;
      backlight_key_q <= RST_BACKLIGHT_KEY;
      reboot_key_q    <= RST_REBOOT_KEY;
      idle_limit_q    <= RST_IDLE_LIMIT;
      message_limit_q <= RST_MESSAGE_LIMIT;
    end else begin
      confirm_key_q   <= confirm_key_d;
      clear_key_q     <= clear_key_d;
      change_key_q    <= change_key_d;
      backlight_key_q <= backlight_key_d;
      reboot_key_q    <= reboot_key_d;
      idle_limit_q    <= idle_limit_d;
      message_limit_q <= message_limit_d;
    end
  end

  assign code_load_o.load  = cfg_we && (cfg_index_i == REG_INITIAL_CODE);
  assign code_load_o.value = cfg_data_i;

  assign limits_o.idle_limit    = idle_limit_q;
  assign limits_o.message_limit = message_limit_q;

  assign s_axis_tready_o = ~q_full_i;
  assign push_o          = s_axis_tvalid_i & s_axis_tready_o;

  assign req_o.is_tick      = s_axis_tuser_i;
  assign req_o.is_reboot    = s_axis_tdata_i == reboot_key_q;
  assign req_o.is_backlight = s_axis_tdata_i == backlight_key_q;
  assign req_o.is_change    = s_axis_tdata_i == change_key_q;
  assign req_o.is_confirm   = s_axis_tdata_i == confirm_key_q;
  assign req_o.is_clear     = (s_axis_tdata_i == clear_key_q) ||
                              (s_axis_tdata_i == CLEAR_ALT_KEY);
  assign req_o.key          = s_axis_tdata_i;

endmodule

// ===== rtl/kcl_fifo.sv =====
// ----------------------------------------------------------------------------
// kcl_fifo
// short request queue between intake and execution
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kcl_fifo import kcl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t wdata_i,
  input  logic pop_i,
  output req_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  req_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == Q_CNT_W'(Q_DEPTH);
  assign empty_o = count_q == '0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/kcl_back.sv =====
// ----------------------------------------------------------------------------
// kcl_back
// lock state machine: timers, entry buffer, code compare and change flow; while the
// result output is not stalled, one request per cycle into a registered result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "keypad_code_lock_controller_assert.svh"

module kcl_back import kcl_pkg::*; #(
  parameter int unsigned CODE_DIGITS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  req_t       req_i,
  output logic       pop_o,
  input  limits_t    limits_i,
  input  code_load_t code_load_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    out_o
);

  logic [3:0]  screen_q, screen_d;
  logic        msg_q, msg_d;
  logic        change_q, change_d;
  logic [1:0]  stage_q, stage_d;
  logic [63:0] entry_q, entry_d;
  logic [3:0]  count_q, count_d;
  logic [63:0] pend_q, pend_d;
  logic [63:0] stored_q, stored_d;
  logic [15:0] idle_q, idle_d;
  logic [15:0] mcnt_q, mcnt_d;
  logic        bl_q, bl_d;
  logic        clk_show_q, clk_show_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, res;
  logic        is_key;
  logic        full;

  assign pop_o       = ~q_empty_i & (~out_valid_q | out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign out_valid_d = pop_o | (out_valid_q & ~out_ready_i);
  assign is_key      = ~req_i.is_tick;

  always_comb begin
    screen_d   = screen_q;
    msg_d      = msg_q;
    change_d   = change_q;
    stage_d    = stage_q;
    entry_d    = entry_q;
    count_d    = count_q;
    pend_d     = pend_q;
    stored_d   = stored_q;
    idle_d     = idle_q;
    mcnt_d     = mcnt_q;
    bl_d       = bl_q;
    clk_show_d = clk_show_q;
    res        = '0;
    full       = 1'b0;

    // timers
    if (req_i.is_tick) begin
      if (idle_d != CNT_MAX) idle_d = idle_d + 16'd1;
      if (msg_d && mcnt_d != CNT_MAX) mcnt_d = mcnt_d + 16'd1;
    end
    if (msg_d && mcnt_d >= limits_i.message_limit) begin
      msg_d    = 1'b0;
      screen_d = SCR_ENTER;
      change_d = 1'b0;
      stage_d  = STG_OLD;
    end

    if (is_key && req_i.is_reboot) begin
      res.reboot_request = 1'b1;
    end else if (is_key && req_i.is_backlight) begin
      entry_d  = '0;
      count_d  = '0;
      msg_d    = 1'b0;
      screen_d = SCR_ENTER;
      bl_d     = ~bl_d;
    end else begin
      // wake handling
      if (is_key) begin
        idle_d = '0;
        if (clk_show_d || (msg_d && screen_d >= SCR_CHANGED && screen_d <= SCR_GRANTED)) begin
          clk_show_d = 1'b0;
          entry_d    = '0;
          count_d    = '0;
          msg_d      = 1'b0;
          screen_d   = SCR_ENTER;
        end
      end
      full = count_d == 4'(CODE_DIGITS);
      if (idle_d >= limits_i.idle_limit) begin
        if (!clk_show_d) begin
          msg_d      = 1'b0;
          screen_d   = SCR_CLOCK;
          clk_show_d = 1'b1;
        end
      end else if (is_key) begin
        if (req_i.is_change) begin
          change_d = 1'b1;
          stage_d  = STG_OLD;
          msg_d    = 1'b0;
          screen_d = SCR_OLD;
          entry_d  = '0;
          count_d  = '0;
        end else if (change_d && req_i.is_confirm) begin
          if (full && stage_d == STG_OLD && entry_d == stored_d) begin
            screen_d = SCR_NEW;
            stage_d  = STG_NEW;
          end else if (full && stage_d == STG_NEW) begin
            pend_d   = entry_d;
            screen_d = SCR_CONFIRM;
            stage_d  = STG_CONFIRM;
          end else begin
            if (full && stage_d == STG_CONFIRM && entry_d == pend_d) begin
              stored_d      = entry_d;
              res.save_code = 1'b1;
              res.new_code  = entry_d;
              screen_d      = SCR_CHANGED;
            end else if (full && stage_d == STG_CONFIRM) begin
              screen_d = SCR_MISMATCH;
            end else begin
              screen_d = SCR_WRONG;
            end
            mcnt_d   = '0;
            msg_d    = 1'b1;
            change_d = 1'b0;
            stage_d  = STG_OLD;
          end
          entry_d = '0;
          count_d = '0;
        end else if (req_i.is_confirm) begin
          if (entry_d == stored_d) begin
            res.unlock_pulse = 1'b1;
            res.good_tone    = 1'b1;
            screen_d         = SCR_GRANTED;
          end else begin
            res.bad_tone = 1'b1;
            screen_d     = SCR_WRONG;
          end
          entry_d = '0;
          count_d = '0;
          mcnt_d  = '0;
          msg_d   = 1'b1;
        end else if (req_i.is_clear) begin
          change_d = 1'b0;
          stage_d  = STG_OLD;
          entry_d  = '0;
          count_d  = '0;
          msg_d    = 1'b0;
          screen_d = SCR_ENTER;
        end else if (change_d || !msg_d) begin
          if (!change_d) screen_d = SCR_ENTER;
          if (!full) begin
            for (int i = 0; i < 8; i++) begin
              if (count_d[2:0] == 3'(i)) entry_d[8*i +: 8] = req_i.key;
            end
            count_d = count_d + 4'd1;
          end
        end
      end
    end

    res.screen         = screen_d;
    res.digits_entered = count_d;
    res.backlight_on   = bl_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_q    <= SCR_ENTER;
      msg_q       <= 1'b0;
      change_q    <= 1'b0;
      stage_q     <= STG_OLD;
      entry_q     <= '0;
      count_q     <= '0;
      pend_q      <= '0;
      stored_q    <= RST_INITIAL_CODE;
      idle_q      <= '0;
      mcnt_q      <= '0;
      bl_q        <= 1'b1;
      clk_show_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        screen_q   <= screen_d;
        msg_q      <= msg_d;
        change_q   <= change_d;
        stage_q    <= stage_d;
        entry_q    <= entry_d;
        count_q    <= count_d;
        pend_q     <= pend_d;
        idle_q     <= idle_d;
        mcnt_q     <= mcnt_d;
        bl_q       <= bl_d;
        clk_show_q <= clk_show_d;
      end
      if (code_load_i.load) begin
        stored_q <= code_load_i.value;
      end else if (pop_o) begin
        stored_q <= stored_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  `KCL_ASSERT(a_stage_needs_mode, (stage_q != STG_OLD) |-> change_q, "stage set outside change mode")
  `KCL_ASSERT(a_count_bound, count_q <= 4'(CODE_DIGITS), "entry count beyond code length")
  `KCL_ASSERT(a_msg_screen, msg_q |-> (screen_q >= SCR_CHANGED && screen_q <= SCR_GRANTED), "message flag on a non-message screen")
  `KCL_ASSERT_NEXT(a_pop_fills, pop_o, out_valid_q, "popped request gave no result")

endmodule
